[sv/clc_pkg.sv]
// shared types and constants for the card number luhn classifier
// no dependencies
package clc_pkg;

	localparam int unsigned COUNT_W = 5;
	localparam int unsigned PAIR_W  = 7;
	localparam int unsigned KIND_W  = 2;

	localparam logic [63:0] MAX_CARD_VALUE = 64'd50000000000000000;

	typedef enum logic [KIND_W-1:0] {
		KIND_INVALID    = 2'd0,
		KIND_AMEX       = 2'd1,
		KIND_VISA       = 2'd2,
		KIND_MASTERCARD = 2'd3
	} card_kind_t;

endpackage

[sv/clc_number_if.sv]
// request channel carrying one binary card number
// no dependencies
interface clc_number_if #(
	parameter int unsigned NUMBER_BITS = 56
);
	logic                   valid;
	logic                   ready;
	logic [NUMBER_BITS-1:0] card_number;

	modport source (output valid, output card_number, input ready);
	modport sink   (input valid, input card_number, output ready);
endinterface

[sv/clc_result_if.sv]
// result channel carrying the card kind, luhn flag, digit count and leading pair
// depends on clc_pkg
interface clc_result_if
	import clc_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  card_kind;
	logic               checksum_ok;
	logic [COUNT_W-1:0] digit_count;
	logic [PAIR_W-1:0]  leading_pair;

	modport source (output valid, output card_kind, output checksum_ok,
		output digit_count, output leading_pair, input ready);
	modport sink   (input valid, input card_kind, input checksum_ok,
		input digit_count, input leading_pair, output ready);
endinterface

[sv/card_number_luhn_classifier_top.sv]
// card number luhn classifier: serial binary to bcd, then digit scan
// depends on clc_pkg, clc_number_if, clc_result_if
//
// One card number is taken per request and one result comes back for it. For an
// item, the binary to bcd conversion shifts in one input bit per cycle, then the
// bcd digits are walked one per cycle from the least significant end, building
// the luhn sum mod 10, the digit count and the leading pair. The next request is
// taken as soon as the scan result moves to the output register, even while that
// result still waits to be taken.
module card_number_luhn_classifier_top
	import clc_pkg::*;
#(
	parameter int unsigned NUMBER_BITS = 56
) (
	input  logic          clk,
	input  logic          arst_n,
	clc_number_if.sink    number,
	clc_result_if.source  result
);

	localparam int unsigned DIGITS = (NUMBER_BITS * 30103) / 100000 + 1;
	localparam int unsigned BCD_W  = 4 * DIGITS;
	localparam int unsigned CNT_W  = $clog2(NUMBER_BITS + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CONV = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_HOLD = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [NUMBER_BITS-1:0] bin_q;
	logic [BCD_W-1:0]       bcd_q;
	logic                   too_big_q;
	logic [COUNT_W-1:0]     pos_q;
	logic [COUNT_W-1:0]     count_q;
	logic [3:0]             sum_q;
	logic [3:0]             prev_q;
	logic [PAIR_W-1:0]      lead_q;

	logic                   out_valid_q;
	card_kind_t             kind_q;
	logic                   ok_q;
	logic [COUNT_W-1:0]     out_count_q;
	logic [PAIR_W-1:0]      out_lead_q;

	logic                   accept;
	logic                   load_out;
	logic [BCD_W-1:0]       bcd_adj;
	logic [3:0]             dig;
	logic [4:0]             dbl;
	logic [4:0]             term;
	logic [4:0]             sum_tmp;
	logic [3:0]             sum_next;
	logic [COUNT_W-1:0]     pos_next;
	logic [PAIR_W-1:0]      lead_next;
	logic                   shape_ok;
	card_kind_t             kind_next;

	assign number.ready = (state_q == ST_IDLE);
	assign accept       = number.valid && number.ready;
	assign load_out     = (state_q == ST_HOLD) && (!out_valid_q || result.ready);

	// add-3 correction on every bcd digit
	always_comb begin
		for (int k = 0; k < DIGITS; k++) begin
			if (bcd_q[4*k +: 4] >= 4'd5) begin
				bcd_adj[4*k +: 4] = bcd_q[4*k +: 4] + 4'd3;
			end else begin
				bcd_adj[4*k +: 4] = bcd_q[4*k +: 4];
			end
		end
	end

	// luhn term, sum and leading pair for the lowest digit
	always_comb begin
		dig      = bcd_q[3:0];
		pos_next = pos_q + 1'b1;
		dbl      = {dig, 1'b0};
		if (!pos_next[0]) begin
			term = (dbl > 5'd9) ? (dbl - 5'd9) : dbl;
		end else begin
			term = {1'b0, dig};
		end
		sum_tmp  = {1'b0, sum_q} + term;
		sum_next = (sum_tmp >= 5'd10) ? 4'(sum_tmp - 5'd10) : sum_tmp[3:0];
		if (pos_next == COUNT_W'(1)) begin
			lead_next = PAIR_W'(dig);
		end else begin
			lead_next = PAIR_W'({dig, 3'b000}) + PAIR_W'({dig, 1'b0}) + PAIR_W'(prev_q);
		end
	end

	// classification from the finished scan
	always_comb begin
		shape_ok  = !too_big_q && (sum_q == 4'd0) &&
			(count_q == COUNT_W'(13) || count_q == COUNT_W'(15) ||
			 count_q == COUNT_W'(16));
		kind_next = KIND_INVALID;
		if (shape_ok) begin
			case (lead_q) inside
				PAIR_W'(34), PAIR_W'(37):  kind_next = KIND_AMEX;
				[PAIR_W'(40):PAIR_W'(49)]: kind_next = KIND_VISA;
				[PAIR_W'(51):PAIR_W'(55)]: kind_next = KIND_MASTERCARD;
				default:                   kind_next = KIND_INVALID;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CONV;
						cnt_q   <= CNT_W'(NUMBER_BITS - 1);
					end
				end
				ST_CONV: begin
					if (cnt_q == '0) begin
						state_q <= ST_SCAN;
						cnt_q   <= CNT_W'(DIGITS - 1);
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_SCAN: begin
					if (cnt_q == '0) begin
						state_q <= ST_HOLD;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_HOLD: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath shift registers
	always_ff @(posedge clk) begin
		if (accept) begin
			bin_q     <= number.card_number;
			bcd_q     <= '0;
			too_big_q <= 64'(number.card_number) > MAX_CARD_VALUE;
			pos_q     <= '0;
			count_q   <= '0;
			sum_q     <= '0;
			prev_q    <= '0;
			lead_q    <= '0;
		end else if (state_q == ST_CONV) begin
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[NUMBER_BITS-1]};
			bin_q <= {bin_q[NUMBER_BITS-2:0], 1'b0};
		end else if (state_q == ST_SCAN) begin
			bcd_q  <= {4'b0000, bcd_q[BCD_W-1:4]};
			pos_q  <= pos_next;
			sum_q  <= sum_next;
			prev_q <= dig;
			if (dig != 4'd0) begin
				count_q <= pos_next;
				lead_q  <= lead_next;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			kind_q      <= kind_next;
			ok_q        <= (sum_q == 4'd0);
			out_count_q <= count_q;
			out_lead_q  <= lead_q;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.card_kind    = kind_q;
	assign result.checksum_ok  = ok_q;
	assign result.digit_count  = out_count_q;
	assign result.leading_pair = out_lead_q;

`ifndef NO_ASSERTIONS
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");

	a_accept_starts_conv: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_CONV)
		else $error("request did not start conversion");

	a_load_only_free: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |-> !load_out)
		else $error("output register overwritten while stalled");

	a_kind_needs_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && kind_next != KIND_INVALID) |->
		(sum_q == 4'd0 && (count_q == COUNT_W'(13) || count_q == COUNT_W'(15) ||
		 count_q == COUNT_W'(16))))
		else $error("valid kind without luhn pass and proper length");

	a_amex_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && kind_next == KIND_AMEX) |->
		(lead_q == PAIR_W'(34) || lead_q == PAIR_W'(37)))
		else $error("amex kind with wrong prefix");
`endif

endmodule
